FILE: hdl/kpscan_pkg.sv
`timescale 1ns / 1ps
// Package for the keypad scanner with number entry.
// Holds the shared widths, key codes, row codes and the scan phase type.
// No dependencies.
package kpscan_pkg;

   // Entry length and derived digit counter width
   localparam int unsigned MAX_DIGITS      = 2;
   localparam int unsigned DIGIT_CNT_W     = $clog2(MAX_DIGITS + 1);

   // Field and register widths
   localparam int unsigned ROW_W           = 4;
   localparam int unsigned COL_W           = 2;
   localparam int unsigned KEY_W           = 4;
   localparam int unsigned VALUE_W         = 14;
   localparam int unsigned SETTLE_W        = 8;
   localparam int unsigned CSR_DATA_W      = 14;
   localparam int unsigned CSR_INDEX_W     = 1;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SATURATE_LIMIT = 1'd1;

   // Register reset values
   localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 8'd5;
   localparam logic [VALUE_W-1:0]  SATURATE_RESET = 14'd99;

   // Row line patterns (active low)
   localparam logic [ROW_W-1:0] ROWS_IDLE = 4'h F;
   localparam logic [ROW_W-1:0] ROW0_LOW  = 4'h E;
   localparam logic [ROW_W-1:0] ROW1_LOW  = 4'h D;
   localparam logic [ROW_W-1:0] ROW2_LOW  = 4'h B;
   localparam logic [ROW_W-1:0] ROW3_LOW  = 4'h 7;

   // Column numbers
   localparam logic [COL_W-1:0] COL_FIRST = 2'd0;
   localparam logic [COL_W-1:0] COL_LAST  = 2'd2;

   // Key codes
   localparam logic [KEY_W-1:0] KEY_NONE  = 4'd0;
   localparam logic [KEY_W-1:0] KEY_STAR  = 4'd10;
   localparam logic [KEY_W-1:0] KEY_ZERO  = 4'd11;
   localparam logic [KEY_W-1:0] KEY_POUND = 4'd12;

   // Scan phases, one-hot
   typedef enum logic [2:0] {
      PH_SETTLE  = 3'b001,
      PH_CONFIRM = 3'b010,
      PH_RELEASE = 3'b100
   } scan_phase_type;

endpackage

FILE: hdl/keypad_scan_number_entry.sv
`timescale 1ns / 1ps
// Keypad scanner, 3 columns by 4 rows, with decimal number entry.
// The result word is registered at the clock edge that takes the tick word.
// Throughput: one tick word per cycle unless req_stall holds it; the state update and the
// times-ten add sit in one combinational pass between the scan state and result registers.
// Reset: synchronous, active high; scan restarts at column 0, entry clears, csr regs reload.
// Depends on kpscan_pkg.
module keypad_scan_number_entry (
   input  logic                               clock,
   input  logic                               reset,
   // tick words in
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [kpscan_pkg::ROW_W-1:0]       req_row_pins,
   // result words out
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [kpscan_pkg::COL_W-1:0]       rsp_col_drive,
   output logic [kpscan_pkg::KEY_W-1:0]       rsp_key_code,
   output logic                               rsp_entry_done,
   output logic                               rsp_entry_cancelled,
   output logic [kpscan_pkg::VALUE_W-1:0]     rsp_entry_value,
   // configuration writes
   input  logic                               csr_write,
   input  logic [kpscan_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kpscan_pkg::CSR_DATA_W-1:0]  csr_data
);
   import kpscan_pkg::*;

   // configuration registers
   logic [SETTLE_W-1:0]    settle_ticks_ff;
   logic [VALUE_W-1:0]     saturate_limit_ff;

   // scan and entry state
   scan_phase_type         scan_phase_ff, scan_phase_in;
   logic [COL_W-1:0]       scan_column_ff, scan_column_in;
   logic [SETTLE_W-1:0]    wait_count_ff, wait_count_in;
   logic [ROW_W-1:0]       first_sample_ff, first_sample_in;
   logic [DIGIT_CNT_W-1:0] digit_count_ff, digit_count_in;
   logic [VALUE_W-1:0]     running_value_ff, running_value_in;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]       col_drive_ff;
   logic [KEY_W-1:0]       key_code_ff, key_code_in;
   logic                   entry_done_ff, entry_done_in;
   logic                   entry_cancelled_ff, entry_cancelled_in;
   logic [VALUE_W-1:0]     entry_value_ff, entry_value_in;

   logic                   accept;
   logic [SETTLE_W-1:0]    wait_inc;
   logic                   wait_elapsed;
   logic                   first_single;
   logic [1:0]             first_row;
   logic [COL_W-1:0]       next_col;
   logic [KEY_W-1:0]       digit;
   logic [VALUE_W-1:0]     times_ten;

   // handshake: a taken result frees the register in the same cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // saturating wait counter, compared after the increment
   assign wait_inc     = (wait_count_ff == '1) ? wait_count_ff : wait_count_ff + 1'b1;
   assign wait_elapsed = (wait_inc >= settle_ticks_ff);
   assign next_col     = (scan_column_ff >= COL_LAST) ? COL_FIRST : scan_column_ff + 1'b1;

   // row decode of the first sample
   always_comb begin
      first_single = 1'b1;
      unique case (first_sample_ff)
         ROW0_LOW: first_row = 2'd0;
         ROW1_LOW: first_row = 2'd1;
         ROW2_LOW: first_row = 2'd2;
         ROW3_LOW: first_row = 2'd3;
         default: begin
            first_row    = 2'd0;
            first_single = 1'b0;
         end
      endcase
   end

   // scan sequencer
   always_comb begin
      scan_phase_in   = scan_phase_ff;
      scan_column_in  = scan_column_ff;
      wait_count_in   = wait_count_ff;
      first_sample_in = first_sample_ff;
      key_code_in     = KEY_NONE;
      unique case (scan_phase_ff)
         PH_CONFIRM: begin
            if (!wait_elapsed) begin
               wait_count_in = wait_inc;
            end else if (req_row_pins != ROWS_IDLE && first_single) begin
               scan_phase_in = PH_RELEASE;
               wait_count_in = '0;
            end else begin
               scan_column_in = next_col;
               scan_phase_in  = PH_SETTLE;
               wait_count_in  = '0;
            end
         end
         PH_RELEASE: begin
            if (req_row_pins == ROWS_IDLE) begin
               // key = row*3 + col + 1
               key_code_in    = {1'b0, first_row, 1'b0} + {2'b00, first_row}
                                + {2'b00, scan_column_ff} + 4'd1;
               scan_column_in = COL_FIRST;
               scan_phase_in  = PH_SETTLE;
               wait_count_in  = '0;
            end
         end
         default: begin
            scan_phase_in = PH_SETTLE;
            if (wait_elapsed) begin
               first_sample_in = req_row_pins;
               scan_phase_in   = PH_CONFIRM;
               wait_count_in   = '0;
            end else begin
               wait_count_in = wait_inc;
            end
         end
      endcase
   end

   // number entry: value*10 as two shifts and an add
   assign digit     = (key_code_in == KEY_ZERO) ? KEY_NONE : key_code_in;
   assign times_ten = VALUE_W'({running_value_ff, 3'b000})
                    + VALUE_W'({running_value_ff, 1'b0});

   always_comb begin
      digit_count_in     = digit_count_ff;
      running_value_in   = running_value_ff;
      entry_done_in      = 1'b0;
      entry_cancelled_in = 1'b0;
      entry_value_in     = '0;
      if (key_code_in == KEY_POUND) begin
         entry_done_in = 1'b1;
      end else if (key_code_in == KEY_STAR) begin
         entry_cancelled_in = 1'b1;
         digit_count_in     = '0;
         running_value_in   = '0;
      end else if (key_code_in != KEY_NONE) begin
         if (digit_count_ff >= DIGIT_CNT_W'(MAX_DIGITS)) begin
            entry_done_in = 1'b1;
         end else begin
            running_value_in = times_ten + VALUE_W'(digit);
            digit_count_in   = digit_count_ff + 1'b1;
         end
      end
      if (entry_done_in) begin
         entry_value_in   = (running_value_ff < saturate_limit_ff) ? running_value_ff
                                                                   : saturate_limit_ff;
         digit_count_in   = '0;
         running_value_in = '0;
      end
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff   <= SETTLE_RESET;
         saturate_limit_ff <= SATURATE_RESET;
         scan_phase_ff     <= PH_SETTLE;
         scan_column_ff    <= COL_FIRST;
         wait_count_ff     <= '0;
         first_sample_ff   <= ROWS_IDLE;
         digit_count_ff    <= '0;
         running_value_ff  <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_SETTLE_TICKS:   settle_ticks_ff   <= csr_data[SETTLE_W-1:0];
               CSR_SATURATE_LIMIT: saturate_limit_ff <= csr_data[VALUE_W-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            scan_phase_ff    <= scan_phase_in;
            scan_column_ff   <= scan_column_in;
            wait_count_ff    <= wait_count_in;
            first_sample_ff  <= first_sample_in;
            digit_count_ff   <= digit_count_in;
            running_value_ff <= running_value_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         col_drive_ff       <= scan_column_ff;
         key_code_ff        <= key_code_in;
         entry_done_ff      <= entry_done_in;
         entry_cancelled_ff <= entry_cancelled_in;
         entry_value_ff     <= entry_value_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_col_drive       = col_drive_ff;
   assign rsp_key_code        = key_code_ff;
   assign rsp_entry_done      = entry_done_ff;
   assign rsp_entry_cancelled = entry_cancelled_ff;
   assign rsp_entry_value     = entry_value_ff;

endmodule
